// ===== design/mmm_pkg.sv =====
// Shared constants, types and arithmetic helpers for the matrix multiplier.
package mmm_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int DIM_W       = 4;
  localparam int IDX_W       = 3;
  localparam int VAL_W       = 32;

  localparam logic [1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [1:0] KIND_LOAD_B  = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  localparam logic [2:0] REG_ROWS_A   = 3'd0;
  localparam logic [2:0] REG_COLS_A   = 3'd1;
  localparam logic [2:0] REG_ROWS_B   = 3'd2;
  localparam logic [2:0] REG_COLS_B   = 3'd3;
  localparam logic [2:0] REG_B_LAYOUT = 3'd4;

  // Token handed from one cell to the next.
  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] sum;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic                    last;
  } mmm_tok_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [VAL_W+1:0] v);
    logic signed [VAL_W+1:0] hi;
    logic signed [VAL_W+1:0] lo;
    hi = {3'b000, {(VAL_W-1){1'b1}}};
    lo = {3'b111, {(VAL_W-1){1'b0}}};
    if (v > hi) sat32 = {1'b0, {(VAL_W-1){1'b1}}};
    else if (v < lo) sat32 = {1'b1, {(VAL_W-1){1'b0}}};
    else sat32 = v[VAL_W-1:0];
  endfunction

endpackage

// ===== design/mmm_cell.sv =====
// One multiply-accumulate cell: holds a product stage and adds into the passing sum.
module mmm_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  mmm_pkg::mmm_tok_t                 tok_in,
  input  logic                              active,
  input  logic signed [mmm_pkg::VAL_W-1:0]  a_val,
  input  logic signed [mmm_pkg::VAL_W-1:0]  b_val,
  output mmm_pkg::mmm_tok_t                 tok_out
);

  logic signed [2*mmm_pkg::VAL_W-1:0] prod;
  logic                               act_d;
  mmm_pkg::mmm_tok_t                  tok_d;
  logic signed [2*mmm_pkg::VAL_W-17:0] shifted;
  logic signed [mmm_pkg::VAL_W-1:0]   qprod;
  logic signed [mmm_pkg::VAL_W+1:0]   acc;

  // Stage one: register the full product; hold while the chain is frozen.
  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= a_val * b_val;
      act_d <= active;
      tok_d.sum  <= tok_in.sum;
      tok_d.row  <= tok_in.row;
      tok_d.col  <= tok_in.col;
      tok_d.last <= tok_in.last;
    end
    if (rst) tok_d.valid <= 1'b0;
    else if (en) tok_d.valid <= tok_in.valid;
  end

  // Floor shift by 16, saturate, then saturating add.
  always_comb begin
    shifted = prod[2*mmm_pkg::VAL_W-1:16];
    if (shifted > $signed({17'd0, {(mmm_pkg::VAL_W-1){1'b1}}}))
      qprod = {1'b0, {(mmm_pkg::VAL_W-1){1'b1}}};
    else if (shifted < $signed({17'h1FFFF, {(mmm_pkg::VAL_W-1){1'b0}}}))
      qprod = {1'b1, {(mmm_pkg::VAL_W-1){1'b0}}};
    else
      qprod = shifted[mmm_pkg::VAL_W-1:0];
    acc = {{2{tok_d.sum[mmm_pkg::VAL_W-1]}}, tok_d.sum} +
          {{2{qprod[mmm_pkg::VAL_W-1]}}, qprod};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_out.row  <= tok_d.row;
      tok_out.col  <= tok_d.col;
      tok_out.last <= tok_d.last;
      tok_out.sum  <= act_d ? mmm_pkg::sat32(acc) : tok_d.sum;
    end
    if (rst) tok_out.valid <= 1'b0;
    else if (en) tok_out.valid <= tok_d.valid;
  end

endmodule

// ===== design/mmm_store.sv =====
// Element store for one matrix; one bank per inner index k, each read once a cycle when re is set.
module mmm_store #(
  parameter int MAX_DIM = mmm_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [mmm_pkg::IDX_W-1:0]         wbank,
  input  logic [mmm_pkg::IDX_W-1:0]         wsel,
  input  logic signed [mmm_pkg::VAL_W-1:0]  wdata,
  input  logic                              re,
  input  logic [mmm_pkg::IDX_W-1:0]         rsel,
  output logic signed [mmm_pkg::VAL_W-1:0]  rdata [MAX_DIM]
);

  for (genvar k = 0; k < MAX_DIM; k++) begin : g_bank
    logic signed [mmm_pkg::VAL_W-1:0] mem [MAX_DIM];
    always_ff @(posedge clk) begin
      if (we && wbank == k[mmm_pkg::IDX_W-1:0]) mem[wsel] <= wdata;
      if (re) rdata[k] <= mem[rsel];
    end
  end

endmodule

// ===== design/matrix_matrix_multiply.sv =====
// Top level of the dense matrix multiplier built on a chain of MAC cells.
//
//  channel   | dir | fields
//  s_axis    | in  | tdata{element_value,col_index,row_index} tuser=kind
//  m_axis    | out | tdata{out_col,out_row,product_value} tlast=last tuser=error
//  apb       | cfg | rows_a@0 cols_a@4 rows_b@8 cols_b@12 b_layout@16
//
// Loads are accepted back to back. A compute item feeds one (i,j) pair
// per cycle, while the output does not stall, into a chain of MAX_DIM
// cells, cell k adding A[i][k]*B[k][j]; each cell has two stages. Intake
// is held during a compute until all results are issued and the chain
// and output register drain, and also while any result, such as an error
// result, waits in the output register. An output stall freezes the whole
// chain. Reset is synchronous and restores the registers to their
// defaults; the element stores are not cleared.
module matrix_matrix_multiply #(
  parameter int MAX_DIM = mmm_pkg::MAX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // row_index[2:0], col_index[5:3], element_value[37:6]
  input  logic [1:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // product_value[31:0], out_row[34:32], out_col[37:35]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // error
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = mmm_pkg::IDX_W;
  localparam int VW = mmm_pkg::VAL_W;
  localparam int LAT = 2 * MAX_DIM + 1;
  localparam int CW = $clog2(LAT + 2) + 1;

  logic [3:0] rows_a, cols_a, rows_b, cols_b;
  logic       b_layout;

  assign pready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a <= 4'd1; cols_a <= 4'd1; rows_b <= 4'd1; cols_b <= 4'd1;
      b_layout <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        mmm_pkg::REG_ROWS_A:   rows_a <= pwdata[3:0];
        mmm_pkg::REG_COLS_A:   cols_a <= pwdata[3:0];
        mmm_pkg::REG_ROWS_B:   rows_b <= pwdata[3:0];
        mmm_pkg::REG_COLS_B:   cols_b <= pwdata[3:0];
        mmm_pkg::REG_B_LAYOUT: b_layout <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      mmm_pkg::REG_ROWS_A:   prdata = {28'd0, rows_a};
      mmm_pkg::REG_COLS_A:   prdata = {28'd0, cols_a};
      mmm_pkg::REG_ROWS_B:   prdata = {28'd0, rows_b};
      mmm_pkg::REG_COLS_B:   prdata = {28'd0, cols_b};
      mmm_pkg::REG_B_LAYOUT: prdata = {31'd0, b_layout};
      default:               prdata = 32'd0;
    endcase
  end

  // Input fields.
  logic [1:0]          in_kind;
  logic [IW-1:0]       in_row, in_col, b_row, b_col;
  logic signed [VW-1:0] in_val;
  assign in_row  = s_axis_tdata[2:0];
  assign in_col  = s_axis_tdata[5:3];
  assign in_val  = s_axis_tdata[37:6];
  assign in_kind = s_axis_tuser;
  assign b_row   = b_layout ? in_col : in_row;
  assign b_col   = b_layout ? in_row : in_col;

  function automatic logic dim_ok(input logic [3:0] d);
    dim_ok = (d != 4'd0) && ({28'd0, d} <= MAX_DIM);
  endfunction

  logic dims_ok;
  assign dims_ok = dim_ok(rows_a) && dim_ok(cols_a) && dim_ok(rows_b) &&
                   dim_ok(cols_b) && (cols_a == rows_b);

  // Control: busy while issuing or draining.
  logic          busy, issuing;
  logic [IW-1:0] ci, cj;
  logic [CW-1:0] drain;
  logic          adv;
  logic          out_full;

  // Advance the whole chain only when the output register can take a result.
  assign adv = !out_full || m_axis_tready;
  assign s_axis_tready = !busy && !out_full;

  logic acc_in;
  assign acc_in = s_axis_tvalid && s_axis_tready;

  logic ld_a, ld_b;
  assign ld_a = acc_in && in_kind == mmm_pkg::KIND_LOAD_A &&
                {29'd0, in_row} < MAX_DIM && {29'd0, in_col} < MAX_DIM;
  assign ld_b = acc_in && in_kind == mmm_pkg::KIND_LOAD_B &&
                {29'd0, b_row} < MAX_DIM && {29'd0, b_col} < MAX_DIM;

  logic start_ok, start_err;
  assign start_ok  = acc_in && in_kind == mmm_pkg::KIND_COMPUTE && dims_ok;
  assign start_err = acc_in && in_kind == mmm_pkg::KIND_COMPUTE && !dims_ok;

  logic iss_last;
  assign iss_last = ({1'b0, ci} == rows_a - 4'd1) && ({1'b0, cj} == cols_b - 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; issuing <= 1'b0; ci <= '0; cj <= '0; drain <= '0;
    end else if (start_ok) begin
      busy <= 1'b1; issuing <= 1'b1; ci <= '0; cj <= '0;
    end else if (busy && adv) begin
      if (issuing) begin
        if (iss_last) begin
          issuing <= 1'b0;
          drain <= CW'(LAT + 1);
        end else if ({1'b0, cj} == cols_b - 4'd1) begin
          cj <= '0; ci <= ci + 1'b1;
        end else begin
          cj <= cj + 1'b1;
        end
      end else if (drain != '0) begin
        drain <= drain - 1'b1;
      end else if (!out_full) begin
        busy <= 1'b0;
      end
    end
  end

  // Stores: A bank k = column, read row ci; B bank k = row, read column cj.
  // Reads are registered; the issue token is registered alongside them to line up.
  logic signed [VW-1:0] a_rd [MAX_DIM];
  logic signed [VW-1:0] b_rd [MAX_DIM];
  logic [IW-1:0] a_rsel, b_rsel;
  assign a_rsel = ci;
  assign b_rsel = cj;

  mmm_store #(.MAX_DIM(MAX_DIM)) u_store_a (
    .clk(clk), .we(ld_a), .wbank(in_col), .wsel(in_row), .wdata(in_val),
    .re(adv), .rsel(a_rsel), .rdata(a_rd)
  );
  mmm_store #(.MAX_DIM(MAX_DIM)) u_store_b (
    .clk(clk), .we(ld_b), .wbank(b_row), .wsel(b_col), .wdata(in_val),
    .re(adv), .rsel(b_rsel), .rdata(b_rd)
  );

  // Every chain register (read data, issue token, operand delays, cells)
  // advances on adv and holds otherwise, so tokens and operands stay aligned.
  // Operands for cell k pass through delay registers so that they meet the token there.
  mmm_pkg::mmm_tok_t tok0;
  always_ff @(posedge clk) begin
    if (rst) tok0.valid <= 1'b0;
    else if (adv) tok0.valid <= busy && issuing;
    if (adv) begin
      tok0.sum  <= '0;
      tok0.row  <= ci;
      tok0.col  <= cj;
      tok0.last <= iss_last;
    end
  end

  mmm_pkg::mmm_tok_t tok [MAX_DIM+1];
  assign tok[0] = tok0;

  for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
    logic signed [VW-1:0] a_op, b_op;
    logic                 act;
    if (k == 0) begin : g_direct
      assign a_op = a_rd[k];
      assign b_op = b_rd[k];
    end else begin : g_dl
      // Delay operands to meet the token at cell k (2k stages).
      logic signed [VW-1:0] a_dl [2*k];
      logic signed [VW-1:0] b_dl [2*k];
      always_ff @(posedge clk) begin
        if (adv) begin
          a_dl[0] <= a_rd[k];
          b_dl[0] <= b_rd[k];
          for (int d = 1; d < 2 * k; d++) begin
            a_dl[d] <= a_dl[d-1];
            b_dl[d] <= b_dl[d-1];
          end
        end
      end
      assign a_op = a_dl[2*k-1];
      assign b_op = b_dl[2*k-1];
    end
    assign act = {28'd0, cols_a} > k;
    mmm_cell u_cell (
      .clk(clk), .rst(rst), .en(adv), .tok_in(tok[k]), .active(act),
      .a_val(a_op), .b_val(b_op), .tok_out(tok[k+1])
    );
  end

  // Output register: take the chain's token on every advance, hold it while
  // the result side stalls. An error result enters only when idle and empty.
  logic [VW-1:0] o_val;
  logic [IW-1:0] o_row, o_col;
  logic          o_last, o_err;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (start_err) begin
      out_full <= 1'b1;
      o_val <= '0; o_row <= '0; o_col <= '0; o_last <= 1'b1; o_err <= 1'b1;
    end else if (adv) begin
      out_full <= tok[MAX_DIM].valid;
      o_val <= tok[MAX_DIM].sum; o_row <= tok[MAX_DIM].row;
      o_col <= tok[MAX_DIM].col; o_last <= tok[MAX_DIM].last; o_err <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_full;
  assign m_axis_tdata  = {2'b00, o_col, o_row, o_val};
  assign m_axis_tlast  = o_last;
  assign m_axis_tuser  = o_err;

endmodule

// ===== tb/sv/mmm_checker.sv =====
// Scoreboard for the matrix multiplier: tracks loads and config, predicts C, compares.
module mmm_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  typedef struct {
    logic signed [31:0] value;
    logic [2:0]         row;
    logic [2:0]         col;
    logic               last;
    logic               err;
  } c_elem_t;

  c_elem_t c_queue[$];

  logic signed [31:0] mat_a [8][8];
  logic signed [31:0] mat_b [8][8];
  logic [3:0] dim_ra, dim_ca, dim_rb, dim_cb;
  logic       layout_t;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp32(p >>> 16);
  endfunction

  function automatic bit dim_valid(logic [3:0] d);
    return d != 0 && d <= mmm_pkg::MAX_DIM_DEF;
  endfunction

  task automatic predict_product();
    c_elem_t e;
    longint acc;
    if (!dim_valid(dim_ra) || !dim_valid(dim_ca) || !dim_valid(dim_rb) ||
        !dim_valid(dim_cb) || dim_ca != dim_rb) begin
      e = '{value: 0, row: 0, col: 0, last: 1'b1, err: 1'b1};
      c_queue.push_back(e);
      return;
    end
    for (int i = 0; i < dim_ra; i++) begin
      for (int j = 0; j < dim_cb; j++) begin
        acc = 0;
        for (int k = 0; k < dim_ca; k++)
          acc = clamp32(acc + fx_mul(mat_a[i][k], mat_b[k][j]));
        e.value = acc[31:0];
        e.row   = i[2:0];
        e.col   = j[2:0];
        e.last  = (i + 1 == dim_ra) && (j + 1 == dim_cb);
        e.err   = 1'b0;
        c_queue.push_back(e);
      end
    end
  endtask

  always @(posedge clk) begin
    logic [2:0] r, c;
    c_elem_t exp_e;
    if (rst) begin
      dim_ra <= 1; dim_ca <= 1; dim_rb <= 1; dim_cb <= 1; layout_t <= 0;
      fail_count <= 0;
      checked <= 0;
      c_queue.delete();
      pending <= 0;
    end else begin
      // config transaction
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          mmm_pkg::REG_ROWS_A:   dim_ra   <= pwdata[3:0];
          mmm_pkg::REG_COLS_A:   dim_ca   <= pwdata[3:0];
          mmm_pkg::REG_ROWS_B:   dim_rb   <= pwdata[3:0];
          mmm_pkg::REG_COLS_B:   dim_cb   <= pwdata[3:0];
          mmm_pkg::REG_B_LAYOUT: layout_t <= pwdata[0];
          default: ;
        endcase
      end
      // input transaction
      if (s_axis_tvalid && s_axis_tready) begin
        r = s_axis_tdata[2:0];
        c = s_axis_tdata[5:3];
        case (s_axis_tuser)
          mmm_pkg::KIND_LOAD_A: mat_a[r][c] = s_axis_tdata[37:6];
          mmm_pkg::KIND_LOAD_B: begin
            if (layout_t) mat_b[c][r] = s_axis_tdata[37:6];
            else          mat_b[r][c] = s_axis_tdata[37:6];
          end
          mmm_pkg::KIND_COMPUTE: predict_product();
          default: ;
        endcase
      end
      // output transaction
      if (m_axis_tvalid && m_axis_tready) begin
        checked <= checked + 1;
        if (c_queue.size() == 0) begin
          $error("unexpected result: value %h row %0d col %0d", m_axis_tdata[31:0],
                 m_axis_tdata[34:32], m_axis_tdata[37:35]);
          fail_count <= fail_count + 1;
        end else begin
          exp_e = c_queue.pop_front();
          if (m_axis_tdata[31:0] !== exp_e.value || m_axis_tdata[34:32] !== exp_e.row ||
              m_axis_tdata[37:35] !== exp_e.col || m_axis_tlast !== exp_e.last ||
              m_axis_tuser !== exp_e.err)
            fail_count <= fail_count + 1;
          if (m_axis_tdata[31:0] !== exp_e.value)
            $error("product_value: expected %h, got %h", exp_e.value, m_axis_tdata[31:0]);
          if (m_axis_tdata[34:32] !== exp_e.row)
            $error("out_row: expected %0d, got %0d", exp_e.row, m_axis_tdata[34:32]);
          if (m_axis_tdata[37:35] !== exp_e.col)
            $error("out_col: expected %0d, got %0d", exp_e.col, m_axis_tdata[37:35]);
          if (m_axis_tlast !== exp_e.last)
            $error("last: expected %0b, got %0b", exp_e.last, m_axis_tlast);
          if (m_axis_tuser !== exp_e.err)
            $error("error: expected %0b, got %0b", exp_e.err, m_axis_tuser);
        end
      end
      pending <= c_queue.size();
    end
  end

endmodule

// ===== tb/sv/tb_matrix_matrix_multiply.sv =====
// Stimulus and verdict for the matrix multiplier testbench.
module tb_matrix_matrix_multiply;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN       = 60;   // well past the 2*MAX_DIM+1 pipeline depth

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;    // row_index[2:0], col_index[5:3], element_value[37:6]
  logic [1:0]  s_axis_tuser;    // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;    // product_value[31:0], out_row[34:32], out_col[37:35]
  logic        m_axis_tlast;
  logic        m_axis_tuser;    // error
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count, pending, checked;
  int cycles;
  int idle_pct;
  int n_items, n_loads, n_computes;

  // shadow of what the block holds, so no compute ever reads an unwritten element
  bit         a_set [8][8];
  bit         b_set [8][8];
  logic [3:0] sh_ra, sh_ca, sh_rb, sh_cb;
  logic       sh_layout;

  matrix_matrix_multiply u_top (.*);

  mmm_checker u_checker (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .pending, .checked
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Watchdog: bail out if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Randomly stall the result side.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= idle_pct);
  end

  // Mix of full-range values (drives saturation) and small ones (exact sums).
  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(32'h000fffff);
      2: return -$urandom_range(32'h000fffff);
      default: return $urandom_range(32'h0003ffff) - 32'h00020000;
    endcase
  endfunction

  task automatic send_item(logic [1:0] kind, logic [2:0] r, logic [2:0] c, logic [31:0] v);
    // random gap before the transaction
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, v, c, r};
    s_axis_tuser  <= kind;
    do @(posedge clk); while (!s_axis_tready);
    n_items++;
    if (kind == mmm_pkg::KIND_LOAD_A) begin
      a_set[r][c] = 1;
      n_loads++;
    end else if (kind == mmm_pkg::KIND_LOAD_B) begin
      if (sh_layout) b_set[c][r] = 1;
      else           b_set[r][c] = 1;
      n_loads++;
    end else if (kind == mmm_pkg::KIND_COMPUTE) begin
      n_computes++;
    end
  endtask

  task automatic hold_off();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      mmm_pkg::REG_ROWS_A:   sh_ra = val[3:0];
      mmm_pkg::REG_COLS_A:   sh_ca = val[3:0];
      mmm_pkg::REG_ROWS_B:   sh_rb = val[3:0];
      mmm_pkg::REG_COLS_B:   sh_cb = val[3:0];
      mmm_pkg::REG_B_LAYOUT: sh_layout = val[0];
      default: ;
    endcase
  endtask

  task automatic set_shape(int ra, int ca, int rb, int cb, int lay);
    hold_off();
    write_reg(mmm_pkg::REG_ROWS_A, ra);
    write_reg(mmm_pkg::REG_COLS_A, ca);
    write_reg(mmm_pkg::REG_ROWS_B, rb);
    write_reg(mmm_pkg::REG_COLS_B, cb);
    write_reg(mmm_pkg::REG_B_LAYOUT, lay);
  endtask

  // Load every operand element this shape will read that is still unwritten, then compute.
  task automatic fill_and_compute();
    bit ok;
    ok = sh_ra != 0 && sh_ra <= 8 && sh_ca != 0 && sh_ca <= 8 &&
         sh_cb != 0 && sh_cb <= 8 && sh_ca == sh_rb;
    if (ok) begin
      for (int i = 0; i < sh_ra; i++)
        for (int k = 0; k < sh_ca; k++)
          if (!a_set[i][k]) send_item(mmm_pkg::KIND_LOAD_A, 3'(i), 3'(k), pick_value());
      for (int k = 0; k < sh_rb; k++)
        for (int j = 0; j < sh_cb; j++)
          if (!b_set[k][j]) begin
            if (sh_layout) send_item(mmm_pkg::KIND_LOAD_B, 3'(j), 3'(k), pick_value());
            else           send_item(mmm_pkg::KIND_LOAD_B, 3'(k), 3'(j), pick_value());
          end
    end
    send_item(mmm_pkg::KIND_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
  endtask

  initial begin
    int ra, ca, cb, phase;
    logic [1:0] kind;
    rst = 1'b1;
    s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
    m_axis_tready = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    cycles = 0; idle_pct = 22;
    n_items = 0; n_loads = 0; n_computes = 0;
    sh_ra = 1; sh_ca = 1; sh_rb = 1; sh_cb = 1; sh_layout = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: default 1x1 shape, positive saturation of the product.
    send_item(mmm_pkg::KIND_LOAD_A, 3'd0, 3'd0, 32'h7fffffff);
    send_item(mmm_pkg::KIND_LOAD_B, 3'd0, 3'd0, 32'h7fffffff);
    send_item(mmm_pkg::KIND_NONE, 3'd7, 3'd7, 32'hffffffff);   // unused kind, dropped
    send_item(mmm_pkg::KIND_COMPUTE, 3'd0, 3'd0, 32'd0);
    // Most negative times itself: 2^62 scaled still overflows.
    send_item(mmm_pkg::KIND_LOAD_A, 3'd0, 3'd0, 32'h80000000);
    send_item(mmm_pkg::KIND_LOAD_B, 3'd0, 3'd0, 32'h80000000);
    send_item(mmm_pkg::KIND_COMPUTE, 3'd7, 3'd7, 32'hffffffff);
    // Opposite signs: negative product, floor rounding on the dropped bits.
    send_item(mmm_pkg::KIND_LOAD_A, 3'd0, 3'd0, 32'hffffffff);
    send_item(mmm_pkg::KIND_LOAD_B, 3'd0, 3'd0, 32'h00000001);
    send_item(mmm_pkg::KIND_COMPUTE, 3'd0, 3'd0, 32'd0);

    // Transposed B, 2x2.
    set_shape(2, 2, 2, 2, 1);
    send_item(mmm_pkg::KIND_LOAD_B, 3'd1, 3'd0, 32'h00010000);
    send_item(mmm_pkg::KIND_LOAD_B, 3'd0, 3'd1, 32'hffff0000);
    fill_and_compute();

    // Bad shapes: zero dimension, inner mismatch, dimension beyond the max.
    set_shape(0, 2, 2, 2, 0);
    send_item(mmm_pkg::KIND_COMPUTE, 3'd0, 3'd0, 32'd0);
    set_shape(3, 4, 5, 2, 0);
    send_item(mmm_pkg::KIND_COMPUTE, 3'd0, 3'd0, 32'd0);
    set_shape(15, 9, 9, 15, 0);
    send_item(mmm_pkg::KIND_COMPUTE, 3'd0, 3'd0, 32'd0);
    set_shape(2, 2, 2, 0, 0);
    send_item(mmm_pkg::KIND_COMPUTE, 3'd0, 3'd0, 32'd0);

    // Largest extents: 8x1 by 1x8 gives all 64 results, 1x8 by 8x1 uses every cell.
    set_shape(8, 1, 1, 8, 0);
    fill_and_compute();
    set_shape(1, 8, 8, 1, 1);
    fill_and_compute();

    // Random phases.
    phase = 0;
    while (n_items < 130) begin
      // first phase runs with no idling on either side
      idle_pct = (phase == 0) ? 0 : 22;
      if ($urandom_range(99) < 15) begin
        set_shape($urandom_range(15), $urandom_range(15), $urandom_range(15),
                  $urandom_range(15), $urandom_range(1));
      end else begin
        ra = ($urandom_range(9) == 0) ? 8 : $urandom_range(1, 4);
        ca = ($urandom_range(19) == 0) ? 8 : $urandom_range(1, 4);
        cb = ($urandom_range(9) == 0) ? 8 : $urandom_range(1, 4);
        set_shape(ra, ca, ca, cb, $urandom_range(1));
      end
      repeat ($urandom_range(5, 15)) begin
        kind = ($urandom_range(19) == 0) ? mmm_pkg::KIND_NONE : 2'($urandom_range(1));
        send_item(kind, 3'($urandom), 3'($urandom), pick_value());
      end
      fill_and_compute();
      phase++;
    end

    hold_off();
    $display("Covered %0d element loads and %0d multiply runs; %0d result elements checked.",
             n_loads, n_computes, checked);
    $display("Shapes spanned 1x1 to 8x8 extents, both B layouts, and invalid dimensions.");
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
